// ===== hw/rtl/ghash_pkg.sv =====
// ----------------------------------------------------------------------------
// ghash_pkg
// Shared types and constants for the GHASH accumulator.
// ----------------------------------------------------------------------------
package ghash_pkg;

    localparam int FIELD_BITS         = 128;
    localparam int WORD_BITS          = 64;
    localparam int DIGIT_BITS_DEFAULT = 8;
    localparam int CFG_INDEX_BITS     = 2;
    localparam logic [7:0] GF_POLY_BYTE = 8'hE1;

    localparam logic [1:0] OP_ABSORB = 2'd0;
    localparam logic [1:0] OP_TAIL   = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_HASH_KEY_FIRST  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HASH_KEY_SECOND = 2'd1;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] block_first;
        logic [63:0] block_second;
        logic [31:0] total_bytes;
        logic        tag_mode;
    } item_t;

    typedef struct packed {
        logic [63:0] tag_first;
        logic [63:0] tag_second;
    } tag_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_EMIT
    } state_t;

endpackage

// ===== hw/rtl/ghash_accumulator.sv =====
// ----------------------------------------------------------------------------
// ghash_accumulator
// GF(2^128) GHASH accumulator, GCM bit order, multiplier bits of H consumed
// one digit per cycle from a shift register.
// ----------------------------------------------------------------------------
// Sequence: a finish beat is accepted, the serial multiply runs, then the emit state
// loads the tag register and tag_valid rises from it.
// Beats: absorb, tail and finish each run the full serial multiply, and no new
// beat is taken until it is done; an unused opcode is taken without a multiply,
// and a finish waits while an older tag is stalled. The accumulator feeds the next beat.
// Reset: accumulator, key registers and control clear; no clearing pass.
module ghash_accumulator
    import ghash_pkg::*;
#(
    parameter int DIGIT_BITS = DIGIT_BITS_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_stall,
    input  item_t                     item,
    output logic                      tag_valid,
    input  logic                      tag_stall,
    output tag_t                      tag,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [WORD_BITS-1:0]      cfg_data
);

    localparam int STEPS = (FIELD_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int CNT_W = $clog2(STEPS + 1);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        step_cnt_reg, step_cnt_next;
    logic [WORD_BITS-1:0]    key_first_reg, key_second_reg;
    logic [FIELD_BITS-1:0]   acc_reg, acc_next;
    logic [FIELD_BITS-1:0]   v_reg, v_next;
    logic [FIELD_BITS-1:0]   z_reg, z_next;
    logic [FIELD_BITS-1:0]   h_sr_reg, h_sr_next;
    logic [FIELD_BITS-1:0]   mask_reg;
    logic                    finish_reg;
    logic                    tag_valid_reg, tag_valid_next;
    tag_t                    tag_reg;

    logic                    accept;
    logic                    load_tag;
    logic [FIELD_BITS-1:0]   v_in;
    logic [WORD_BITS-1:0]    len_bits;

    assign accept   = item_valid && !item_stall;
    assign len_bits = {29'd0, item.total_bytes, 3'd0};
    assign load_tag = (state_reg == ST_EMIT) && (!tag_valid_reg || !tag_stall);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (item.opcode == OP_ABSORB || item.opcode == OP_TAIL
                               || item.opcode == OP_FINISH))
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (step_cnt_reg == LAST_STEP)
                begin
                    state_next = finish_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (load_tag)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        item_stall = (state_reg != ST_IDLE);
        cfg_ready  = 1'b1;
        tag_valid  = tag_valid_reg;
        tag        = tag_reg;
    end

    // operand select on accept
    always_comb
    begin
        v_in = acc_reg;
        case (item.opcode)
            OP_ABSORB:
            begin
                v_in = acc_reg ^ {item.block_first, item.block_second};
            end
            OP_FINISH:
            begin
                if (item.tag_mode)
                begin
                    v_in = acc_reg ^ {len_bits, {WORD_BITS{1'b0}}};
                end
                else
                begin
                    v_in = acc_reg ^ {{WORD_BITS{1'b0}}, len_bits};
                end
            end
            default:
            begin
                v_in = acc_reg;
            end
        endcase
    end

    // one digit of the serial multiply
    always_comb
    begin
        logic [FIELD_BITS-1:0] v;
        logic [FIELD_BITS-1:0] z;
        logic                  carry;
        v = v_reg;
        z = z_reg;
        for (int k = 0; k < DIGIT_BITS; k++)
        begin
            if (h_sr_reg[FIELD_BITS-1-k])
            begin
                z = z ^ v;
            end
            carry = v[0];
            v = {1'b0, v[FIELD_BITS-1:1]};
            if (carry)
            begin
                v[FIELD_BITS-1 -: 8] = v[FIELD_BITS-1 -: 8] ^ GF_POLY_BYTE;
            end
        end
        v_next    = v;
        z_next    = z;
        h_sr_next = h_sr_reg << DIGIT_BITS;
    end

    always_comb
    begin
        step_cnt_next  = step_cnt_reg;
        acc_next       = acc_reg;
        tag_valid_next = tag_valid_reg;
        if (tag_valid_reg && !tag_stall)
        begin
            tag_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                step_cnt_next = '0;
            end
            ST_MUL:
            begin
                step_cnt_next = step_cnt_reg + CNT_W'(1);
                if (step_cnt_reg == LAST_STEP)
                begin
                    step_cnt_next = '0;
                    acc_next      = z_next;
                end
            end
            ST_EMIT:
            begin
                step_cnt_next = '0;
                if (load_tag)
                begin
                    acc_next       = '0;
                    tag_valid_next = 1'b1;
                end
            end
            default:
            begin
                step_cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_cnt_reg   <= '0;
            acc_reg        <= '0;
            key_first_reg  <= '0;
            key_second_reg <= '0;
            tag_valid_reg  <= 1'b0;
            finish_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_cnt_reg  <= step_cnt_next;
            acc_reg       <= acc_next;
            tag_valid_reg <= tag_valid_next;
            if (accept)
            begin
                finish_reg <= (item.opcode == OP_FINISH);
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_HASH_KEY_FIRST)
                begin
                    key_first_reg <= cfg_data;
                end
                else if (cfg_index == REG_HASH_KEY_SECOND)
                begin
                    key_second_reg <= cfg_data;
                end
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            v_reg    <= v_in;
            z_reg    <= '0;
            h_sr_reg <= {key_first_reg, key_second_reg};
            if (item.opcode == OP_FINISH && item.tag_mode)
            begin
                mask_reg <= {item.block_first, item.block_second};
            end
            else
            begin
                mask_reg <= '0;
            end
        end
        else if (state_reg == ST_MUL)
        begin
            v_reg    <= v_next;
            z_reg    <= z_next;
            h_sr_reg <= h_sr_next;
        end
        if (load_tag)
        begin
            tag_reg <= acc_reg ^ mask_reg;
        end
    end

    // checks
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> (step_cnt_reg <= LAST_STEP))
        else $error("multiply step counter out of range");

    a_idle_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (step_cnt_reg == '0))
        else $error("step counter not cleared in idle");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        load_tag |=> (acc_reg == '0) && tag_valid_reg)
        else $error("finish did not clear accumulator or raise tag");

    a_mul_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.opcode == OP_ABSORB || item.opcode == OP_TAIL))
        |=> (state_reg == ST_MUL))
        else $error("absorb beat did not start multiply");

endmodule
